FILE: hw/rtl/rsoi_pkg.sv
// ----------------------------------------------------------------------------
// rsoi_pkg
// Shared types and constants of the range spoof offset injector.
// ----------------------------------------------------------------------------
package rsoi_pkg;

   localparam int DivNumW   = 53;   // dividend / quotient width of the shared divider
   localparam int DivDenW   = 21;   // divisor width of the shared divider
   localparam int RadW      = 36;   // radicand width of the square root unit
   localparam int RootW     = 18;   // root width, t1 fits in it
   localparam int DivSteps  = DivNumW;
   localparam int SqrtSteps = RootW;
   localparam int CntW      = 6;

   localparam logic [11:0]        RC_ON_THRESHOLD = 12'd1600;
   localparam logic [3:0]         GOOD_COUNT_MAX  = 4'd10;
   localparam logic [19:0]        ONE_MILLION     = 20'd1000000;
   // ceil(2^45 / 15625), exact floor division for dividends below 2^31
   localparam logic [31:0]        RECIP_15625     = 32'd2251799814;

   localparam logic [1:0] RANGE_GOOD = 2'd0;
   localparam logic [1:0] RANGE_LOW  = 2'd1;
   localparam logic [1:0] RANGE_HIGH = 2'd2;

   localparam logic [2:0] REG_OFFSET   = 3'd0;
   localparam logic [2:0] REG_ACCEL    = 3'd1;
   localparam logic [2:0] REG_SIMPLE   = 3'd2;
   localparam logic [2:0] REG_ATTACK   = 3'd3;
   localparam logic [2:0] REG_USE_RC   = 3'd4;
   localparam logic [2:0] REG_MIN      = 3'd5;
   localparam logic [2:0] REG_MAX      = 3'd6;

   typedef struct packed {
      logic [15:0] offset_cm;
      logic [15:0] accel_cm_s2;
      logic        simple_mode;
      logic        attack_enable;
      logic        use_rc_switch;
      logic [15:0] min_range_cm;
      logic [15:0] max_range_cm;
   } cfg_type;

   typedef struct packed {
      logic capture;
      logic arm;
      logic div_step;
      logic scale;
      logic sqrt_load;
      logic sqrt_step;
      logic t_store;
      logic square;
      logic mul_lo;
      logic mul_hi;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic need_arm;
      logic profile;
      logic out_free;
   } status_type;

   typedef enum logic [11:0] {
      ST_IDLE   = 12'b000000000001,
      ST_DECIDE = 12'b000000000010,
      ST_ARM    = 12'b000000000100,
      ST_DIV1   = 12'b000000001000,
      ST_SQLD   = 12'b000000010000,
      ST_SQRT   = 12'b000000100000,
      ST_TSTORE = 12'b000001000000,
      ST_SQ     = 12'b000010000000,
      ST_MULLO  = 12'b000100000000,
      ST_MULHI  = 12'b001000000000,
      ST_SCALE  = 12'b010000000000,
      ST_FIN    = 12'b100000000000
   } state_type;

endpackage

FILE: hw/rtl/rsoi_regs.sv
// ----------------------------------------------------------------------------
// rsoi_regs
// Configuration register file behind the csr port.
// ----------------------------------------------------------------------------
module rsoi_regs (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [4:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready,
   output rsoi_pkg::cfg_type cfg
);
   import rsoi_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr;
   logic [2:0] idx;

   assign csr_pready = 1'b1;
   assign wr  = csr_psel & csr_penable & csr_pwrite;
   assign idx = csr_paddr[4:2];
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (idx)
            REG_OFFSET: cfg_in.offset_cm     = csr_pwdata[15:0];
            REG_ACCEL:  cfg_in.accel_cm_s2   = csr_pwdata[15:0];
            REG_SIMPLE: cfg_in.simple_mode   = csr_pwdata[0];
            REG_ATTACK: cfg_in.attack_enable = csr_pwdata[0];
            REG_USE_RC: cfg_in.use_rc_switch = csr_pwdata[0];
            REG_MIN:    cfg_in.min_range_cm  = csr_pwdata[15:0];
            REG_MAX:    cfg_in.max_range_cm  = csr_pwdata[15:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_OFFSET: csr_prdata = {16'd0, cfg_ff.offset_cm};
         REG_ACCEL:  csr_prdata = {16'd0, cfg_ff.accel_cm_s2};
         REG_SIMPLE: csr_prdata = {31'd0, cfg_ff.simple_mode};
         REG_ATTACK: csr_prdata = {31'd0, cfg_ff.attack_enable};
         REG_USE_RC: csr_prdata = {31'd0, cfg_ff.use_rc_switch};
         REG_MIN:    csr_prdata = {16'd0, cfg_ff.min_range_cm};
         REG_MAX:    csr_prdata = {16'd0, cfg_ff.max_range_cm};
         default:    csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.offset_cm     <= 16'd0;
         cfg_ff.accel_cm_s2   <= 16'd0;
         cfg_ff.simple_mode   <= 1'b0;
         cfg_ff.attack_enable <= 1'b0;
         cfg_ff.use_rc_switch <= 1'b0;
         cfg_ff.min_range_cm  <= 16'd20;
         cfg_ff.max_range_cm  <= 16'd700;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: hw/rtl/rsoi_ctrl.sv
// ----------------------------------------------------------------------------
// rsoi_ctrl
// Sequencer: steps the shared divider, square root and multiplier per beat.
// ----------------------------------------------------------------------------
module rsoi_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  rsoi_pkg::status_type status,
   output rsoi_pkg::cmd_type    cmd
);
   import rsoi_pkg::*;

   state_type       state_ff, state_in;
   logic [CntW-1:0] cnt_ff, cnt_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            priority if (status.need_arm) state_in = ST_ARM;
            else if (status.profile)      state_in = ST_SQ;
            else                          state_in = ST_FIN;
         end
         ST_ARM: begin
            cmd.arm  = 1'b1;
            cnt_in   = CntW'(DivSteps - 1);
            state_in = ST_DIV1;
         end
         ST_DIV1: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - 1'b1;
            if (cnt_ff == '0) state_in = ST_SQLD;
         end
         ST_SQLD: begin
            cmd.sqrt_load = 1'b1;
            cnt_in        = CntW'(SqrtSteps - 1);
            state_in      = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            cnt_in        = cnt_ff - 1'b1;
            if (cnt_ff == '0) state_in = ST_TSTORE;
         end
         ST_TSTORE: begin
            cmd.t_store = 1'b1;
            state_in    = ST_DECIDE;
         end
         ST_SQ: begin
            cmd.square = 1'b1;
            state_in   = ST_MULLO;
         end
         ST_MULLO: begin
            cmd.mul_lo = 1'b1;
            state_in   = ST_MULHI;
         end
         ST_MULHI: begin
            cmd.mul_hi = 1'b1;
            state_in   = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_FIN;
         end
         ST_FIN: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

FILE: hw/rtl/rsoi_dp.sv
// ----------------------------------------------------------------------------
// rsoi_dp
// Datapath: latch state, restoring divider, digit square root, multiplier,
// reciprocal scaling, saturation, range check and the output register.
// ----------------------------------------------------------------------------
module rsoi_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  rsoi_pkg::cfg_type    cfg,
   input  rsoi_pkg::cmd_type    cmd,
   output rsoi_pkg::status_type status,
   input  logic [63:0]          req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [39:0]          rsp_tdata
);
   import rsoi_pkg::*;

   // captured beat
   logic [15:0] meas_ff, meas_in;
   logic [31:0] now_ff, now_in;
   logic [11:0] rc_ff, rc_in;
   // attack state
   logic             started_ff, started_in;
   logic [15:0]      latched_ff, latched_in;
   logic [31:0]      start_ff, start_in;
   logic [RootW-1:0] half_ff, half_in;
   logic [RadW-1:0]  tsq_ff, tsq_in;
   logic [3:0]       good_ff, good_in;
   // arithmetic units
   logic [DivNumW-1:0] quo_ff, quo_in;
   logic [DivDenW-1:0] rem_ff, rem_in;
   logic [RadW-1:0]    rad_ff, rad_in;
   logic [19:0]        srem_ff, srem_in;
   logic [RootW-1:0]   root_ff, root_in;
   logic [RadW-1:0]    wsq_ff, wsq_in;
   logic [51:0]        acc_ff, acc_in;
   // output register
   logic        out_valid_ff, out_valid_in;
   logic [39:0] out_data_ff, out_data_in;

   logic              attack, active, le_t, beyond, done, neg;
   logic [31:0]       elapsed;
   logic [15:0]       mag_off;
   logic [18:0]       w_far;
   logic [RootW-1:0]  w;
   logic [36:0]       q_wide;
   logic [RadW-1:0]   q;
   logic [35:0]       arm_prod;
   logic [DivDenW-1:0] divisor;
   logic [DivDenW:0]  dsh, ddiff;
   logic [21:0]       ssh, strial, sdiff;
   logic [62:0]       recip_prod;
   logic [17:0]       scaled;
   logic [31:0]       mag;
   logic signed [33:0] value;
   logic [15:0]       reported;
   logic [1:0]        range_st;
   logic [3:0]        good_next;

   assign attack  = cfg.attack_enable | (cfg.use_rc_switch & (rc_ff > RC_ON_THRESHOLD));
   assign active  = started_ff & attack;
   assign elapsed = now_ff - start_ff;
   assign le_t    = elapsed <= {14'd0, half_ff};
   assign beyond  = {1'b0, elapsed} > {14'd0, half_ff, 1'b0};
   assign done    = cfg.simple_mode | beyond;
   assign neg     = cfg.offset_cm[15];
   assign mag_off = neg ? (~cfg.offset_cm + 16'd1) : cfg.offset_cm;

   assign status.need_arm = ~started_ff & attack;
   assign status.profile  = active & ~cfg.simple_mode & ~beyond;
   assign status.out_free = ~out_valid_ff | rsp_tready;

   // past t1 the profile is mirrored: q = 2*t1^2 - (2*t1 - e)^2
   assign w_far  = {half_ff, 1'b0} - elapsed[18:0];
   assign w      = le_t ? elapsed[RootW-1:0] : w_far[RootW-1:0];
   assign q_wide = le_t ? {1'b0, wsq_ff} : ({tsq_ff, 1'b0} - {1'b0, wsq_ff});
   assign q      = q_wide[RadW-1:0];

   assign arm_prod = 36'(mag_off) * 36'(ONE_MILLION);

   assign divisor = {5'd0, cfg.accel_cm_s2};
   assign dsh     = {rem_ff, quo_ff[DivNumW-1]};
   assign ddiff   = dsh - {1'b0, divisor};

   assign ssh    = {srem_ff, rad_ff[RadW-1 -: 2]};
   assign strial = {2'b00, root_ff, 2'b01};
   assign sdiff  = ssh - strial;

   // divide by 2e6 as a shift by 7 and a reciprocal multiply by 1/15625;
   // a dividend of 2^38 or more gives a magnitude that saturates either way
   assign recip_prod = 63'(quo_ff[37:7]) * 63'(RECIP_15625);
   assign scaled     = (|quo_ff[DivNumW-1:38]) ? 18'h20000 : recip_prod[62:45];

   // a zero offset carries no sign, so nothing is added
   assign mag   = (done | (mag_off == 16'd0)) ? {16'd0, mag_off} : quo_ff[31:0];
   assign value = active ? (neg ? 34'(latched_ff) - 34'(mag) : 34'(latched_ff) + 34'(mag))
                         : 34'(meas_ff);

   always_comb begin
      priority if (value < 0)             reported = 16'd0;
      else if (value > 34'sd65535)        reported = 16'hFFFF;
      else                                reported = value[15:0];
   end

   always_comb begin
      priority if (reported > cfg.max_range_cm) range_st = RANGE_HIGH;
      else if (reported < cfg.min_range_cm)     range_st = RANGE_LOW;
      else                                      range_st = RANGE_GOOD;
   end

   assign good_next = (range_st != RANGE_GOOD) ? 4'd0 :
                      (good_ff < GOOD_COUNT_MAX) ? good_ff + 4'd1 : good_ff;

   always_comb begin
      meas_in      = meas_ff;
      now_in       = now_ff;
      rc_in        = rc_ff;
      started_in   = started_ff;
      latched_in   = latched_ff;
      start_in     = start_ff;
      half_in      = half_ff;
      tsq_in       = tsq_ff;
      good_in      = good_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      rad_in       = rad_ff;
      srem_in      = srem_ff;
      root_in      = root_ff;
      wsq_in       = wsq_ff;
      acc_in       = acc_ff;
      out_data_in  = out_data_ff;
      out_valid_in = out_valid_ff & ~rsp_tready;

      if (cmd.capture) begin
         meas_in = req_tdata[15:0];
         now_in  = req_tdata[47:16];
         rc_in   = req_tdata[59:48];
      end
      if (cmd.arm) begin
         started_in = 1'b1;
         latched_in = meas_ff;
         start_in   = now_ff;
         quo_in     = DivNumW'(arm_prod);
         rem_in     = '0;
      end
      if (cmd.div_step) begin
         if (!ddiff[DivDenW]) begin
            rem_in = ddiff[DivDenW-1:0];
            quo_in = {quo_ff[DivNumW-2:0], 1'b1};
         end else begin
            rem_in = dsh[DivDenW-1:0];
            quo_in = {quo_ff[DivNumW-2:0], 1'b0};
         end
      end
      if (cmd.sqrt_load) begin
         // zero acceleration gives t1 of zero
         rad_in  = (cfg.accel_cm_s2 == 16'd0) ? '0 : quo_ff[RadW-1:0];
         srem_in = '0;
         root_in = '0;
      end
      if (cmd.sqrt_step) begin
         rad_in = {rad_ff[RadW-3:0], 2'b00};
         if (!sdiff[21]) begin
            srem_in = sdiff[19:0];
            root_in = {root_ff[RootW-2:0], 1'b1};
         end else begin
            srem_in = ssh[19:0];
            root_in = {root_ff[RootW-2:0], 1'b0};
         end
      end
      if (cmd.t_store) begin
         half_in = root_ff;
         tsq_in  = 36'(root_ff) * 36'(root_ff);
      end
      if (cmd.square) wsq_in = 36'(w) * 36'(w);
      if (cmd.mul_lo) acc_in = 52'(cfg.accel_cm_s2) * 52'(q[17:0]);
      if (cmd.mul_hi) begin
         // rounded dividend: a*q + 1e6
         quo_in = DivNumW'(acc_ff)
                + ((DivNumW'(cfg.accel_cm_s2) * DivNumW'(q[35:18])) << 18)
                + DivNumW'(ONE_MILLION);
         rem_in = '0;
      end
      if (cmd.scale) quo_in = DivNumW'(scaled);
      if (cmd.finish) begin
         good_in      = good_next;
         out_valid_in = 1'b1;
         out_data_in  = {active & done, active, good_next, range_st, meas_ff, reported};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff   <= 1'b0;
         latched_ff   <= 16'd0;
         start_ff     <= 32'd0;
         half_ff      <= '0;
         tsq_ff       <= '0;
         good_ff      <= 4'd0;
         out_valid_ff <= 1'b0;
      end else begin
         started_ff   <= started_in;
         latched_ff   <= latched_in;
         start_ff     <= start_in;
         half_ff      <= half_in;
         tsq_ff       <= tsq_in;
         good_ff      <= good_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      meas_ff     <= meas_in;
      now_ff      <= now_in;
      rc_ff       <= rc_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      rad_ff      <= rad_in;
      srem_ff     <= srem_in;
      root_ff     <= root_in;
      wsq_ff      <= wsq_in;
      acc_ff      <= acc_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

FILE: hw/rtl/range_spoof_offset_injector.sv
// ----------------------------------------------------------------------------
// range_spoof_offset_injector
// Adds a stepped or bang-bang ramped spoof offset to rangefinder readings.
// ----------------------------------------------------------------------------
// with the attack off or in simple mode a beat goes straight to the output;
// a profile beat squares, does two multiplies, then a reciprocal scale by
// 1/2e6; the arming beat runs the 53-step divider and the 18-step square
// root, then the profile if it applies. one beat at a time, plus any wait on
// rsp_tready. reset (synchronous) clears the attack latch, t1, the good
// counter and the output valid flag, and resets the config registers.
module range_spoof_offset_injector (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [15:0] measured_cm, [47:16] time_ms, [59:48] rc_pulse_us, [63:60] zero
   input  logic [63:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [15:0] reported_cm, [31:16] real_cm, [33:32] range_status,
   // [37:34] valid_count, [38] attack_active, [39] profile_done
   output logic [39:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import rsoi_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   rsoi_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rsoi_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   rsoi_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
